// ===== rtl/prime_factorizer_spf_sieve_top_defines.svh =====
// assertion macros used by the checker file pfs_checker
`ifndef PRIME_FACTORIZER_SPF_SIEVE_TOP_DEFINES_SVH
`define PRIME_FACTORIZER_SPF_SIEVE_TOP_DEFINES_SVH

// next-cycle implication, off while reset is high
`define PFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define PFS_ASSERT_NEXT_NR(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pfs_pkg.sv =====
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared constants and state encoding of the smallest-prime-factor factorizer.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int TABLE_SIZE_DEF  = 65536;
  localparam int TABLE_DEPTH_MAX = 65536;
  localparam int MAX_RESULTS     = 16;
  localparam int NUM_W           = 16;
  localparam int SPF_W           = 8;
  localparam int OUTER_W         = 9;
  localparam int INNER_W         = 17;
  localparam int CNT_W           = 4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_OUTER,
    ST_OUTER_CHK,
    ST_INNER_RD,
    ST_INNER_WR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_DIVIDE
  } state_t;

endpackage

// ===== rtl/prime_factorizer_spf_sieve_top.sv =====
// ----------------------------------------------------------------------------
// prime_factorizer_spf_sieve_top
// Builds a smallest-prime-factor table with a sieve in one memory, then splits
// each request into prime factors by table lookup and a serial divider.
// ----------------------------------------------------------------------------
// after rst the table is cleared (one entry a cycle, min(TABLE_SIZE, 65536)
//   entries), then sieved: each struck multiple is read, then written only
//   if still empty; s_axis_tready stays low until the table is built
// each factor is looked up in the table, then all but the last are divided out by
//   the bit-serial divider; factors pass the read and output registers in turn
// one number is worked on at a time; a result waits in the output register
module prime_factorizer_spf_sieve_top #(
  parameter int TABLE_SIZE = pfs_pkg::TABLE_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [pfs_pkg::NUM_W-1:0] s_axis_tdata,   // [15:0] number
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [pfs_pkg::NUM_W-1:0] m_axis_tdata,   // [15:0] factor
  output logic                      m_axis_tlast    // last
);

  localparam int DEPTH = (TABLE_SIZE < pfs_pkg::TABLE_DEPTH_MAX) ?
                         TABLE_SIZE : pfs_pkg::TABLE_DEPTH_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = pfs_pkg::NUM_W;
  localparam int SW    = pfs_pkg::SPF_W;
  localparam int OW    = pfs_pkg::OUTER_W;
  localparam int IW    = pfs_pkg::INNER_W;
  localparam int CW    = pfs_pkg::CNT_W;

  // table memory
  logic [SW-1:0] mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [SW-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  pfs_pkg::state_t state, state_next;

  logic [AW-1:0]   clr_addr;
  logic [OW-1:0]   outer;
  logic [IW-1:0]   inner;
  logic [2*OW-1:0] outer_sq;
  logic [NW-1:0]   rem;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   dcnt;
  logic [SW-1:0]   divisor;
  logic [SW-1:0]   acc;
  logic            rd_ok;

  logic            slot_free;
  logic            rem_in_range;
  logic            inner_in_range;
  logic            outer_go;
  logic [SW-1:0]   spf;
  logic            emit_last;
  logic [SW:0]     div_trial;
  logic [SW:0]     div_diff;
  logic            div_ge;

  assign outer_sq       = {{OW{1'b0}}, outer} * {{OW{1'b0}}, outer};
  assign outer_go       = outer_sq < (2*OW)'(DEPTH);
  assign inner_in_range = inner < IW'(DEPTH);
  assign rem_in_range   = {1'b0, rem} < (NW+1)'(DEPTH);
  assign slot_free      = !m_axis_tvalid || m_axis_tready;
  assign spf            = rd_ok ? rd_data : '0;
  // a table entry below two means the remainder is prime (or 0 or 1) or lies beyond the table
  assign emit_last      = (spf < SW'(2)) || (cnt == CW'(pfs_pkg::MAX_RESULTS - 1));

  // restoring divider step, one quotient bit a cycle shifted into rem
  assign div_trial = {acc, rem[NW-1]};
  assign div_ge    = div_trial >= {1'b0, divisor};
  assign div_diff  = div_trial - {1'b0, divisor};

  assign s_axis_tready = (state == pfs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = AW'(inner);
    case (state)
      pfs_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = pfs_pkg::ST_OUTER;
        end
      end
      pfs_pkg::ST_OUTER: begin
        if (outer_go) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(outer);
          state_next = pfs_pkg::ST_OUTER_CHK;
        end else begin
          state_next = pfs_pkg::ST_IDLE;
        end
      end
      pfs_pkg::ST_OUTER_CHK: begin
        if (rd_data != '0) begin
          state_next = pfs_pkg::ST_OUTER;
        end else begin
          state_next = pfs_pkg::ST_INNER_RD;
        end
      end
      pfs_pkg::ST_INNER_RD: begin
        if (inner_in_range) begin
          mem_re     = 1'b1;
          state_next = pfs_pkg::ST_INNER_WR;
        end else begin
          state_next = pfs_pkg::ST_OUTER;
        end
      end
      pfs_pkg::ST_INNER_WR: begin
        // keep the smallest factor already written
        mem_we     = (rd_data == '0);
        mem_waddr  = AW'(inner);
        mem_wdata  = outer[SW-1:0];
        state_next = pfs_pkg::ST_INNER_RD;
      end
      pfs_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = pfs_pkg::ST_LOOKUP;
        end
      end
      pfs_pkg::ST_LOOKUP: begin
        mem_re     = rem_in_range;
        mem_raddr  = AW'(rem);
        state_next = pfs_pkg::ST_DECIDE;
      end
      pfs_pkg::ST_DECIDE: begin
        if (slot_free) begin
          state_next = emit_last ? pfs_pkg::ST_IDLE : pfs_pkg::ST_DIVIDE;
        end
      end
      pfs_pkg::ST_DIVIDE: begin
        if (dcnt == CW'(NW - 1)) begin
          state_next = pfs_pkg::ST_LOOKUP;
        end
      end
      default: begin
        state_next = pfs_pkg::ST_CLEAR;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      outer    <= OW'(2);
    end else begin
      case (state)
        pfs_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          outer    <= OW'(2);
        end
        pfs_pkg::ST_OUTER_CHK: begin
          if (rd_data != '0) begin
            outer <= outer + OW'(1);
          end else begin
            inner <= outer_sq[IW-1:0];
          end
        end
        pfs_pkg::ST_INNER_RD: begin
          if (!inner_in_range) begin
            outer <= outer + OW'(1);
          end
        end
        pfs_pkg::ST_INNER_WR: begin
          inner <= inner + IW'(outer);
        end
        pfs_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            rem <= s_axis_tdata;
            cnt <= '0;
          end
        end
        pfs_pkg::ST_LOOKUP: begin
          rd_ok <= rem_in_range;
        end
        pfs_pkg::ST_DECIDE: begin
          if (slot_free && !emit_last) begin
            divisor <= spf;
            acc     <= '0;
            dcnt    <= '0;
            cnt     <= cnt + CW'(1);
          end
        end
        pfs_pkg::ST_DIVIDE: begin
          acc  <= div_ge ? div_diff[SW-1:0] : div_trial[SW-1:0];
          rem  <= {rem[NW-2:0], div_ge};
          dcnt <= dcnt + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == pfs_pkg::ST_DECIDE && slot_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pfs_pkg::ST_DECIDE && slot_free) begin
      m_axis_tdata <= emit_last ? rem : {{(NW-SW){1'b0}}, spf};
      m_axis_tlast <= emit_last;
    end
  end

endmodule

// ===== rtl/pfs_checker.sv =====
// ----------------------------------------------------------------------------
// pfs_checker
// Port-level checks of the factorizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "prime_factorizer_spf_sieve_top_defines.svh"

module pfs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [pfs_pkg::NUM_W-1:0] s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [pfs_pkg::NUM_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);

  logic in_req;
  logic out_stall;

  assign in_req    = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // stalled result holds
  `PFS_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // table rebuild after reset keeps the input closed
  `PFS_ASSERT_NEXT_NR(a_rst_busy, clk, rst, !s_axis_tready, "input ready right after reset")

  // reset drops any pending result
  `PFS_ASSERT_NEXT_NR(a_rst_out, clk, rst, !m_axis_tvalid, "result valid right after reset")

  // one number at a time: an accepted request closes the input
  `PFS_ASSERT_NEXT(a_one_item, clk, rst, in_req, !s_axis_tready, "input ready after a request")

endmodule

bind prime_factorizer_spf_sieve_top pfs_checker u_pfs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams numbers into the smallest-prime-factor factorizer and checks every
// returned factor and its last flag against a trial-division factorization,
// with random idle bursts on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
  import pfs_pkg::*;

  localparam int STALL_LIMIT = 1200000;
  localparam int DRAIN_CYCLES = 64;
  localparam int TAIL_ITEMS = 20;
  localparam int RANDOM_ITEMS = 80;

  typedef struct packed {
    logic [NUM_W-1:0] factor;
    logic             last;
  } factor_item_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [NUM_W-1:0] s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [NUM_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  logic [NUM_W-1:0] pending_numbers[$];
  factor_item_t     expected_factors[$];
  bit               failed = 1'b0;
  logic             tail_phase = 1'b0;
  int               send_gap = 0;
  int               recv_stall = 0;
  int               quiet_cycles = 0;

  prime_factorizer_spf_sieve_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // expected factors of one request, smallest first
  function automatic void push_factors(input logic [NUM_W-1:0] number);
    int unsigned  rest;
    int unsigned  div;
    int           count;
    factor_item_t item;
    rest = number;
    if (rest < 2) begin
      item.factor = number;
      item.last = 1'b1;
      expected_factors.push_back(item);
      return;
    end
    count = 0;
    while (count < MAX_RESULTS) begin
      div = 2;
      while (div * div <= rest && rest % div != 0) div++;
      if (div * div > rest || count == MAX_RESULTS - 1) begin
        item.factor = rest[NUM_W-1:0];
        item.last = 1'b1;
        expected_factors.push_back(item);
        return;
      end
      item.factor = div[NUM_W-1:0];
      item.last = 1'b0;
      expected_factors.push_back(item);
      count++;
      rest = rest / div;
    end
  endfunction

  function automatic logic [NUM_W-1:0] random_number();
    int unsigned value;
    int unsigned p;
    int unsigned d;
    int          kind;
    int          steps;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      value = $urandom_range(0, 65535);
    end else if (kind <= 6) begin
      // smooth numbers give long factor lists
      value = 1;
      steps = $urandom_range(1, 15);
      repeat (steps) begin
        case ($urandom_range(0, 10))
          0, 1, 2: p = 2;
          3, 4:    p = 3;
          5:       p = 5;
          6:       p = 7;
          7:       p = 13;
          8:       p = 127;
          9:       p = 251;
          default: p = 257;
        endcase
        if (value * p <= 65535) value = value * p;
      end
    end else if (kind == 7) begin
      // walk down to a prime
      value = $urandom_range(257, 65535) | 1;
      d = 3;
      while (d * d <= value) begin
        if (value % d == 0) begin
          value = value - 2;
          d = 3;
        end else begin
          d = d + 2;
        end
      end
    end else if (kind == 8) begin
      value = $urandom_range(0, 40);
    end else begin
      value = $urandom_range(0, 1) ? (1 << $urandom_range(0, 15))
                                    : 65535 - $urandom_range(0, 255);
    end
    return value[NUM_W-1:0];
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) push_factors(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_numbers.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 12) - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_numbers.pop_front();
        end
      end
      tail_phase <= pending_numbers.size() <= TAIL_ITEMS;
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_factors.size() == 0) begin
          $display("%0t: unexpected result, expected none, got factor %0d last %0d",
                   $time, m_axis_tdata, m_axis_tlast);
          failed = 1'b1;
        end else begin
          if (m_axis_tdata !== expected_factors[0].factor) begin
            $display("%0t: factor mismatch, expected %0d, got %0d",
                     $time, expected_factors[0].factor, m_axis_tdata);
            failed = 1'b1;
          end
          if (m_axis_tlast !== expected_factors[0].last) begin
            $display("%0t: last mismatch on factor %0d, expected %0d, got %0d",
                     $time, expected_factors[0].factor, expected_factors[0].last,
                     m_axis_tlast);
            failed = 1'b1;
          end
          void'(expected_factors.pop_front());
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // no handshake for too long, including the table build after reset
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout with %0d requests and %0d factors outstanding",
               $time, pending_numbers.size(), expected_factors.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // zero, unit, primes, extremes and long factor lists
    pending_numbers.push_back(16'd0);
    pending_numbers.push_back(16'd1);
    pending_numbers.push_back(16'd2);
    pending_numbers.push_back(16'd3);
    pending_numbers.push_back(16'd4);
    pending_numbers.push_back(16'd6);
    pending_numbers.push_back(16'd49);
    pending_numbers.push_back(16'd65535);
    pending_numbers.push_back(16'd65534);
    pending_numbers.push_back(16'd32768);
    pending_numbers.push_back(16'd32767);
    pending_numbers.push_back(16'd65521);
    pending_numbers.push_back(16'd65025);
    pending_numbers.push_back(16'd63001);
    pending_numbers.push_back(16'd64507);
    pending_numbers.push_back(16'd43690);
    pending_numbers.push_back(16'd21845);
    pending_numbers.push_back(16'd49152);
    pending_numbers.push_back(16'd257);
    pending_numbers.push_back(16'd1);
    pending_numbers.push_back(16'd0);
    repeat (RANDOM_ITEMS) pending_numbers.push_back(random_number());

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_numbers.size() != 0 || s_axis_tvalid || expected_factors.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_factors.size() != 0)
      $display("%0t: %0d expected factors never arrived", $time, expected_factors.size());
    if (!failed && expected_factors.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pfs_pkg.sv
rtl/prime_factorizer_spf_sieve_top.sv
rtl/pfs_checker.sv
tb/sv/testbench.sv
